// ===== design/pq_pkg.sv =====
package pq_pkg;

    // Default number of palette slots
    localparam int PALETTE_DEPTH_DEF = 16;

    // Register map, as word indexes
    localparam logic REG_PALETTE_COUNT = 1'b0;
    localparam logic REG_QUIET_MODE    = 1'b1;

    localparam logic [4:0] PALETTE_COUNT_RESET = 5'd14;

    // Item kinds carried in tuser
    localparam logic OP_QUANTIZE = 1'b0;
    localparam logic OP_LOAD     = 1'b1;

    // Slot that holds the quiet base tone when the count is two or more
    localparam int QUIET_ENTRY = 1;

    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 3 * CHAN_W;
    localparam int SQ_W    = 2 * CHAN_W;
    localparam int DIST_W  = SQ_W + 2;
    localparam int SLOT_W  = 4;
    localparam int APB_AW  = 3;

endpackage

// ===== design/palette_quantizer.sv =====
// Channel    | Direction | Word contents (lowest bit first)
// -----------+-----------+------------------------------------------------------
// s_axis     | in        | tuser: operation; tdata: entry_index, red, green, blue
// m_axis     | out       | tuser: quieted; tdata: red, green, blue, nearest_index
// APB        | in        | reg 0 palette_count at 0x0, reg 1 quiet_mode at 0x4
//
// A load word is written straight into the palette memory.
// A quantize word sweeps n entries, n being the active count clamped to
// 1..PALETTE_DEPTH: the single read port of the palette memory delivers one
// entry per cycle, followed by a squaring stage and a compare stage.
// Reset clears control state only; the palette holds no value until loaded.
// A waiting result does not block input; a finished search holds until the
// output register is free.

module palette_quantizer #(
    parameter int PALETTE_DEPTH = pq_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // APB configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [pq_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // Input stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [31:0]              s_axis_tdata,  // entry_index[3:0], red[11:4],
                                                    // green[19:12], blue[27:20]
    input  logic                     s_axis_tuser,  // operation
    // Output stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [31:0]              m_axis_tdata,  // red[7:0], green[15:8],
                                                    // blue[23:16], nearest_index[27:24]
    output logic                     m_axis_tuser   // quieted
);
    import pq_pkg::*;

    localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN
    } t_state;

    t_state r_state;

    logic [4:0]         r_palette_count;
    logic               r_quiet_mode;

    logic [COLOR_W-1:0] r_palette [PALETTE_DEPTH];
    logic [COLOR_W-1:0] r_rd_data;

    logic [CNT_W-1:0]   r_n;
    logic [IDX_W-1:0]   r_last_idx;
    logic [IDX_W-1:0]   r_quiet_idx;
    logic [IDX_W-1:0]   r_issue_idx;
    logic [COLOR_W-1:0] r_pix;

    logic               r_p1_vld;
    logic [IDX_W-1:0]   r_p1_idx;
    logic               r_p2_vld;
    logic [IDX_W-1:0]   r_p2_idx;
    logic [COLOR_W-1:0] r_p2_color;
    logic [SQ_W-1:0]    r_p2_sq_r;
    logic [SQ_W-1:0]    r_p2_sq_g;
    logic [SQ_W-1:0]    r_p2_sq_b;

    logic [DIST_W-1:0]  r_best_dist;
    logic [IDX_W-1:0]   r_best_idx;
    logic [COLOR_W-1:0] r_best_color;
    logic [COLOR_W-1:0] r_quiet_color;

    logic               in_acc;
    logic               in_is_load;
    logic [SLOT_W-1:0]  in_slot;
    logic [COLOR_W-1:0] in_pix;
    logic               mem_we;
    logic               mem_re;
    logic [CNT_W-1:0]   n_n;
    logic               cfg_we;
    logic               search_done;
    logic               out_free;
    logic               quiet_sel;
    logic [COLOR_W-1:0] out_color;
    logic [CHAN_W-1:0]  dr, dg, db;
    logic [DIST_W-1:0]  cand_dist;

    // ---------------------------------------------------------------- APB
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_PALETTE_COUNT: prdata = {27'd0, r_palette_count};
            REG_QUIET_MODE:    prdata = {31'd0, r_quiet_mode};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_count <= PALETTE_COUNT_RESET;
            r_quiet_mode    <= 1'b0;
        end else if (cfg_we) begin
            if (paddr[2] == REG_PALETTE_COUNT) begin
                r_palette_count <= pwdata[4:0];
            end else begin
                r_quiet_mode <= pwdata[0];
            end
        end
    end

    // ---------------------------------------------------------- input side
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_is_load    = (s_axis_tuser == OP_LOAD);
    assign in_slot       = s_axis_tdata[SLOT_W-1:0];
    assign in_pix        = s_axis_tdata[SLOT_W +: COLOR_W];

    // Slots beyond the memory are silently dropped.
    assign mem_we = in_acc && in_is_load && (int'(in_slot) < PALETTE_DEPTH);
    assign mem_re = (r_state == ST_SWEEP);

    // Active count, clamped into 1..PALETTE_DEPTH.
    always_comb begin
        if (r_palette_count == 5'd0) begin
            n_n = CNT_W'(1);
        end else if (int'(r_palette_count) > PALETTE_DEPTH) begin
            n_n = CNT_W'(PALETTE_DEPTH);
        end else begin
            n_n = CNT_W'(r_palette_count);
        end
    end

    // ------------------------------------------------------ palette memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_palette[IDX_W'(in_slot)] <= in_pix;
        end
        if (mem_re) begin
            r_rd_data <= r_palette[r_issue_idx];
        end
    end

    // ------------------------------------------------------------- datapath
    always_comb begin
        dr = (r_rd_data[23:16] > r_pix[23:16]) ? r_rd_data[23:16] - r_pix[23:16]
                                               : r_pix[23:16] - r_rd_data[23:16];
        dg = (r_rd_data[15:8] > r_pix[15:8]) ? r_rd_data[15:8] - r_pix[15:8]
                                             : r_pix[15:8] - r_rd_data[15:8];
        db = (r_rd_data[7:0] > r_pix[7:0]) ? r_rd_data[7:0] - r_pix[7:0]
                                           : r_pix[7:0] - r_rd_data[7:0];
    end

    assign cand_dist = DIST_W'(r_p2_sq_r) + DIST_W'(r_p2_sq_g) + DIST_W'(r_p2_sq_b);

    always_ff @(posedge i_clk) begin
        if (in_acc && !in_is_load) begin
            r_pix       <= in_pix;
            r_n         <= n_n;
            r_last_idx  <= IDX_W'(n_n - CNT_W'(1));
            r_quiet_idx <= (n_n >= CNT_W'(2)) ? IDX_W'(QUIET_ENTRY) : '0;
        end

        r_p1_idx <= r_issue_idx;

        if (r_p1_vld) begin
            r_p2_sq_r  <= SQ_W'(dr) * SQ_W'(dr);
            r_p2_sq_g  <= SQ_W'(dg) * SQ_W'(dg);
            r_p2_sq_b  <= SQ_W'(db) * SQ_W'(db);
            r_p2_color <= r_rd_data;
            r_p2_idx   <= r_p1_idx;
            if (r_p1_idx == r_quiet_idx) begin
                r_quiet_color <= r_rd_data;
            end
        end

        // Strictly smaller replaces the best, so ties keep the lower index.
        if (r_p2_vld && ((r_p2_idx == '0) || (cand_dist < r_best_dist))) begin
            r_best_dist  <= cand_dist;
            r_best_idx   <= r_p2_idx;
            r_best_color <= r_p2_color;
        end
    end

    // -------------------------------------------------------- result select
    assign search_done = (r_state == ST_DRAIN) && !r_p1_vld && !r_p2_vld;
    assign out_free    = !m_axis_tvalid || m_axis_tready;
    assign quiet_sel   = r_quiet_mode && (CNT_W'(r_best_idx) < (r_n >> 1));

    always_comb begin
        if (!r_quiet_mode) begin
            out_color = r_best_color;
        end else if (quiet_sel) begin
            out_color = r_quiet_color;
        end else begin
            out_color = r_pix;
        end
    end

    // --------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_issue_idx   <= '0;
            r_p1_vld      <= 1'b0;
            r_p2_vld      <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_p1_vld <= mem_re;
            r_p2_vld <= r_p1_vld;

            // The output register takes a finished result or empties once read.
            if (search_done && out_free) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    r_issue_idx <= '0;
                    if (in_acc && !in_is_load) begin
                        r_state <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    r_issue_idx <= r_issue_idx + 1'b1;
                    if (r_issue_idx == r_last_idx) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (search_done && out_free) begin
                        m_axis_tdata  <= {4'd0, SLOT_W'(r_best_idx), out_color};
                        m_axis_tuser  <= quiet_sel;
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------- assertions
    a_write_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_state == ST_IDLE)
        else $error("palette written while a search runs");

    a_quantize_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !in_is_load) |=> r_state == ST_SWEEP)
        else $error("quantize word did not start a sweep");

    a_pipe_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_vld || r_p2_vld) |-> r_state == ST_DRAIN || r_state == ST_SWEEP)
        else $error("compare pipeline busy outside a search");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (search_done && out_free) |=> m_axis_tvalid && r_state == ST_IDLE)
        else $error("finished search did not produce a result");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

    import pq_pkg::*;

    localparam int DEPTH         = PALETTE_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 24;
    localparam int CHUNK_ITEMS   = 100;
    localparam int MAX_REPORTS   = 200;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [3:0] index;
        logic       quieted;
    } t_colour_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // entry_index[3:0], red[11:4], green[19:12], blue[27:20]
    logic [31:0] s_axis_tdata  = '0;
    // operation
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // red[7:0], green[15:8], blue[23:16], nearest_index[27:24]
    logic [31:0] m_axis_tdata;
    // quieted
    logic        m_axis_tuser;

    // Shadow copy of the block's palette and registers
    logic [23:0] palette_shadow [DEPTH];
    logic [4:0]  count_shadow = PALETTE_COUNT_RESET;
    logic        quiet_shadow = 1'b0;

    t_colour_result pending_colours [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int report_count  = 0;
    int pixels_sent   = 0;
    int loads_sent    = 0;
    int quieted_seen  = 0;
    int config_writes = 0;

    palette_quantizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8 * 1000000);
        $display("FAIL");
        $finish;
    end

    function automatic int colour_distance(input logic [23:0] a, input logic [23:0] b);
        int dr;
        int dg;
        int db;
        dr = int'(a[23:16]) - int'(b[23:16]);
        dg = int'(a[15:8]) - int'(b[15:8]);
        db = int'(a[7:0]) - int'(b[7:0]);
        return dr * dr + dg * dg + db * db;
    endfunction

    function automatic int active_entries();
        int n;
        n = int'(count_shadow);
        if (n < 1) n = 1;
        if (n > DEPTH) n = DEPTH;
        return n;
    endfunction

    function automatic t_colour_result nearest_colour(input logic [23:0] pix);
        int n;
        int best;
        int best_dist;
        int d;
        logic [23:0] colour;
        t_colour_result res;
        n = active_entries();
        best = 0;
        best_dist = colour_distance(pix, palette_shadow[0]);
        // Only a strictly closer entry wins, so ties go to the lowest index.
        for (int i = 1; i < n; i++) begin
            d = colour_distance(pix, palette_shadow[i]);
            if (d < best_dist) begin
                best_dist = d;
                best = i;
            end
        end
        colour = palette_shadow[best];
        res.quieted = 1'b0;
        if (quiet_shadow) begin
            if (best < n / 2) begin
                colour = (n >= 2) ? palette_shadow[QUIET_ENTRY] : palette_shadow[0];
                res.quieted = 1'b1;
            end else begin
                colour = pix;
            end
        end
        res.red   = colour[23:16];
        res.green = colour[15:8];
        res.blue  = colour[7:0];
        res.index = best[3:0];
        return res;
    endfunction

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_colour_result want;
        t_colour_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.red     = m_axis_tdata[7:0];
            got.green   = m_axis_tdata[15:8];
            got.blue    = m_axis_tdata[23:16];
            got.index   = m_axis_tdata[27:24];
            got.quieted = m_axis_tuser;
            if (pending_colours.size() == 0) begin
                error_count++;
                $display("%0t: result with nothing expected: %h", $time, got);
            end else begin
                want = pending_colours.pop_front();
                if (got.quieted) quieted_seen++;
                if (got != want) begin
                    error_count++;
                    report_count++;
                    if (report_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch expected r=%h g=%h b=%h idx=%0d q=%b",
                                 $time, want.red, want.green, want.blue, want.index,
                                 want.quieted);
                        $display("%0t:          actual   r=%h g=%h b=%h idx=%0d q=%b",
                                 $time, got.red, got.green, got.blue, got.index,
                                 got.quieted);
                    end else if (report_count == MAX_REPORTS + 1) begin
                        $display("%0t: further mismatches are counted only", $time);
                    end
                end
            end
        end
    end

    task automatic send_word(input logic op, input logic [3:0] slot, input logic [23:0] rgb);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, rgb[7:0], rgb[15:8], rgb[23:16], slot};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (op == OP_LOAD) begin
            palette_shadow[slot] = rgb;
            loads_sent++;
        end else begin
            pending_colours.insert(pending_colours.size(), nearest_colour(rgb));
            pixels_sent++;
        end
    endtask

    // Drops the input valid and waits until every result is out and any load
    // still in flight has landed.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_colours.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic reg_idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(reg_idx) << 2;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [4:0] count, input logic quiet);
        wait_drained();
        apb_write(REG_PALETTE_COUNT, {27'b0, count});
        apb_write(REG_QUIET_MODE, {31'b0, quiet});
        count_shadow = count;
        quiet_shadow = quiet;
        config_writes += 2;
    endtask

    // Every slot is written before any search reads it.
    task automatic test_palette_load();
        logic [23:0] colours [DEPTH];
        colours = '{24'h000000, 24'h202020, 24'h400000, 24'h400000,
                    24'h004000, 24'h000080, 24'h505050, 24'hFF0000,
                    24'h00FF00, 24'h0000FF, 24'h808080, 24'hFFFF00,
                    24'h00FFFF, 24'hFF00FF, 24'hC0C0C0, 24'hFFFFFF};
        for (int i = 0; i < DEPTH; i++) send_word(OP_LOAD, 4'(i), colours[i]);
    endtask

    task automatic test_nearest_match();
        send_word(OP_QUANTIZE, 4'hF, 24'h000000);
        send_word(OP_QUANTIZE, 4'h0, 24'hFFFFFF);
        // Slots two and three hold the same colour; the lower one must win.
        send_word(OP_QUANTIZE, 4'h5, 24'h400000);
        // Equally far from slots zero and two.
        send_word(OP_QUANTIZE, 4'hA, 24'h200000);
        send_word(OP_QUANTIZE, 4'h0, 24'hFF0000);
        send_word(OP_QUANTIZE, 4'h0, 24'h0000FF);
        send_word(OP_QUANTIZE, 4'h3, 24'h123456);
    endtask

    task automatic test_quiet_and_counts();
        set_config(5'd16, 1'b1);
        send_word(OP_QUANTIZE, 4'h0, 24'hFFFFFF);
        send_word(OP_QUANTIZE, 4'h0, 24'h101010);
        // A count of zero acts as one: nothing is quieted, the pixel passes through.
        set_config(5'd0, 1'b1);
        send_word(OP_QUANTIZE, 4'h0, 24'hABCDEF);
        set_config(5'd1, 1'b1);
        send_word(OP_QUANTIZE, 4'h0, 24'h00FF80);
        set_config(5'd2, 1'b1);
        send_word(OP_QUANTIZE, 4'h0, 24'h000000);
        send_word(OP_QUANTIZE, 4'h0, 24'hFFFFFF);
        set_config(5'd31, 1'b0);
        send_word(OP_QUANTIZE, 4'h0, 24'hFEFEFE);
    endtask

    function automatic logic [7:0] jitter_channel(input logic [7:0] c);
        int v;
        v = int'(c) + $urandom_range(16) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    task automatic random_chunk(input int items, input bit pause_midway);
        int kind;
        int src;
        logic [23:0] rgb;
        for (int k = 0; k < items; k++) begin
            if (pause_midway && k == items / 2) wait_drained();
            kind = $urandom_range(99);
            if (kind < 15) begin
                // Some loads copy an existing slot so that ties keep appearing.
                if ($urandom_range(4) == 0)
                    rgb = palette_shadow[$urandom_range(DEPTH - 1)];
                else
                    rgb = 24'($urandom);
                send_word(OP_LOAD, 4'($urandom_range(DEPTH - 1)), rgb);
            end else begin
                src = $urandom_range(active_entries() - 1);
                if (kind < 50) begin
                    rgb = 24'($urandom);
                end else if (kind < 85) begin
                    rgb = {jitter_channel(palette_shadow[src][23:16]),
                           jitter_channel(palette_shadow[src][15:8]),
                           jitter_channel(palette_shadow[src][7:0])};
                end else begin
                    rgb = palette_shadow[src];
                end
                send_word(OP_QUANTIZE, 4'($urandom), rgb);
            end
        end
    endtask

    task automatic test_random_phase(input int phase, input int send_pct, input int recv_pct);
        logic [4:0] count_plan [18];
        count_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd8, 5'd2,
                       5'd15, 5'd17, 5'd3, 5'd16, 5'd9, 5'd4,
                       5'd14, 5'd5, 5'd16, 5'd1, 5'd12, 5'd7};
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int c = 0; c < 6; c++) begin
            set_config(count_plan[phase * 6 + c], 1'((c + phase) % 2));
            random_chunk(CHUNK_ITEMS, c == 3);
        end
    endtask

    initial begin
        send_idle_pct = 15;
        recv_idle_pct = 62;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_palette_load();
        test_nearest_match();
        test_quiet_and_counts();
        test_random_phase(0, 15, 62);
        test_random_phase(1, 62, 15);
        test_random_phase(2, 0, 0);

        wait_drained();
        $display("Quantized %0d pixels (%0d quieted) and loaded %0d palette entries,",
                 pixels_sent, quieted_seen, loads_sent);
        $display("with %0d register writes covering counts 0 to 31 in both modes.",
                 config_writes);
        if (error_count == 0 && pending_colours.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pq_pkg.sv
design/palette_quantizer.sv
dv/tb_top.sv
